[design/stdp_weight_update_macros.svh]
// Assertion macros shared by the STDP weight update RTL.
`ifndef STDP_WEIGHT_UPDATE_MACROS_SVH
`define STDP_WEIGHT_UPDATE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every clock edge outside reset
`define STDP_ASSERT_HOLDS(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset
`define STDP_ASSERT_NEXT(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error(msg);

`else

`define STDP_ASSERT_HOLDS(label, cond, check, msg)
`define STDP_ASSERT_NEXT(label, cond, check, msg)

`endif

`endif

[design/stdp_wu_pkg.sv]
// Shared types and constants for the STDP weight update block.
`default_nettype none

package stdp_wu_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int EXP_ROM_W   = 17;

   // exp(-1 ms / 20 ms) as Q0.32, used to build the decay table
   localparam logic [63:0] EXP_STEP_Q32 = 64'd4085499269;
   localparam logic [16:0] ONE_Q16      = 17'h10000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LTP_STEP,
      CSR_LTD_RATE,
      CSR_WINDOW_OFFSET,
      CSR_WEIGHT_CAP,
      CSR_LTP_WINDOW,
      CSR_LTD_WINDOW,
      CSR_LTP_RECIP,
      CSR_LTD_RECIP
   } csr_index_type;

   typedef struct packed {
      logic [15:0] ltp_step;
      logic [15:0] ltd_rate;
      logic [15:0] window_offset;
      logic [15:0] weight_cap;
      logic [15:0] ltp_window;
      logic [15:0] ltd_window;
      logic [15:0] ltp_window_recip;
      logic [15:0] ltd_window_recip;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      ltp_step:         16'd66,
      ltd_rate:         16'd688,
      window_offset:    16'd16384,
      weight_cap:       16'd18022,
      ltp_window:       16'd1280,
      ltd_window:       16'd1344,
      ltp_window_recip: 16'd13107,
      ltd_window_recip: 16'd12483
   };

   // Per-stage control that travels with each item
   typedef struct packed {
      logic valid;
      logic potentiated;
      logic linear;
   } item_ctl_type;

endpackage

`default_nettype wire

[design/stdp_wu_csr.sv]
// Configuration register file for the STDP weight update block.
`default_nettype none

module stdp_wu_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [stdp_wu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]                        csr_data,
   output stdp_wu_pkg::cfg_type                    cfg
);
   import stdp_wu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are taken every cycle
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LTP_STEP:      cfg_in.ltp_step         = csr_data;
            CSR_LTD_RATE:      cfg_in.ltd_rate         = csr_data;
            CSR_WINDOW_OFFSET: cfg_in.window_offset    = csr_data;
            CSR_WEIGHT_CAP:    cfg_in.weight_cap       = csr_data;
            CSR_LTP_WINDOW:    cfg_in.ltp_window       = csr_data;
            CSR_LTD_WINDOW:    cfg_in.ltd_window       = csr_data;
            CSR_LTP_RECIP:     cfg_in.ltp_window_recip = csr_data;
            CSR_LTD_RECIP:     cfg_in.ltd_window_recip = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[design/stdp_wu_timing.sv]
// Front pipeline stages: spike interval, window test, ROM read and offset product.
`default_nettype none

module stdp_wu_timing #(
   parameter int EXP_TABLE_DEPTH  = 256,
   parameter int DT_FRACTION_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                in_valid,
   input  wire logic [15:0]                         in_weight,
   input  wire logic [31:0]                         in_pre_time,
   input  wire logic [31:0]                         in_post_time,
   input  wire stdp_wu_pkg::cfg_type                cfg,
   output stdp_wu_pkg::item_ctl_type                out_ctl,
   output logic [15:0]                              out_weight,
   output logic [stdp_wu_pkg::EXP_ROM_W-1:0]        out_exp,
   output logic [32-DT_FRACTION_BITS:0]             out_lin_term
);
   import stdp_wu_pkg::*;

   localparam int P_W   = 32 - DT_FRACTION_BITS;
   localparam int G_W   = P_W + 1;
   localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

   typedef logic [EXP_ROM_W-1:0] rom_type [EXP_TABLE_DEPTH];

   // Decay table: entry k is exp(-k/20) in Q1.16, built by repeated rounding
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] acc;
      int          k;
      acc = 64'd1 << 32;
      for (k = 0; k < EXP_TABLE_DEPTH; k++) begin
         rom[k] = EXP_ROM_W'((acc + 64'd32768) >> 16);
         acc    = (acc * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
      end
      return rom;
   endfunction

   localparam rom_type EXP_ROM = build_rom();

   // Stage 1: interval and direction
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_pot_ff, s1_pot_in;
   logic [31:0] s1_dt_ff, s1_dt_in;
   logic [15:0] s1_w_ff;

   assign s1_valid_in = in_valid;
   assign s1_pot_in   = (in_pre_time <= in_post_time);
   assign s1_dt_in    = s1_pot_in ? (in_post_time - in_pre_time)
                                  : (in_pre_time - in_post_time);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pot_ff <= s1_pot_in;
         s1_dt_ff  <= s1_dt_in;
         s1_w_ff   <= in_weight;
      end
   end

   // Stage 2: window test, table index and linear fraction
   logic [15:0]      window;
   logic [15:0]      recip;
   logic [31:0]      excess;
   logic [P_W-1:0]   idx_full;
   logic [31:0]      p_prod;
   item_ctl_type     s2_ctl_ff, s2_ctl_in;
   logic [IDX_W-1:0] s2_idx_ff, s2_idx_in;
   logic [P_W-1:0]   s2_p_ff, s2_p_in;
   logic [15:0]      s2_w_ff;

   assign window   = s1_pot_ff ? cfg.ltp_window : cfg.ltd_window;
   assign recip    = s1_pot_ff ? cfg.ltp_window_recip : cfg.ltd_window_recip;
   assign excess   = s1_dt_ff - {16'd0, window};
   assign idx_full = excess[31:DT_FRACTION_BITS];
   assign p_prod   = {16'd0, s1_dt_ff[15:0]} * {16'd0, recip};

   always_comb begin
      s2_ctl_in.valid       = s1_valid_ff;
      s2_ctl_in.potentiated = s1_pot_ff;
      s2_ctl_in.linear      = (s1_dt_ff <= {16'd0, window});
      // Far past the window the index sticks at the last entry
      if (idx_full > P_W'(EXP_TABLE_DEPTH - 1)) begin
         s2_idx_in = IDX_W'(EXP_TABLE_DEPTH - 1);
      end else begin
         s2_idx_in = idx_full[IDX_W-1:0];
      end
      s2_p_in = p_prod[31:DT_FRACTION_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (advance) begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_idx_ff <= s2_idx_in;
         s2_p_ff   <= s2_p_in;
         s2_w_ff   <= s1_w_ff;
      end
   end

   // Stage 3: registered ROM read and window offset product
   logic [16:0]          off_factor;
   logic [16+P_W:0]      g_prod;
   item_ctl_type         s3_ctl_ff;
   logic [EXP_ROM_W-1:0] s3_exp_ff;
   logic [G_W-1:0]       s3_g_ff, s3_g_in;
   logic [15:0]          s3_w_ff;

   // Potentiation scales by 1 + F, depression by 1 - F
   assign off_factor = s2_ctl_ff.potentiated ? (ONE_Q16 + {1'b0, cfg.window_offset})
                                             : (ONE_Q16 - {1'b0, cfg.window_offset});
   assign g_prod     = (17 + P_W)'(off_factor) * (17 + P_W)'(s2_p_ff);
   assign s3_g_in    = g_prod[16+P_W:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_exp_ff <= EXP_ROM[s2_idx_ff];
         s3_g_ff   <= s3_g_in;
         s3_w_ff   <= s2_w_ff;
      end
   end

   assign out_ctl      = s3_ctl_ff;
   assign out_weight   = s3_w_ff;
   assign out_exp      = s3_exp_ff;
   assign out_lin_term = s3_g_ff;

endmodule

`default_nettype wire

[design/stdp_wu_scale.sv]
// Back pipeline stages: step factor, amplitude scaling, weight update and clamp.
`default_nettype none
`include "stdp_weight_update_macros.svh"

module stdp_wu_scale #(
   parameter int DT_FRACTION_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire stdp_wu_pkg::item_ctl_type    in_ctl,
   input  wire logic [15:0]                  in_weight,
   input  wire logic [stdp_wu_pkg::EXP_ROM_W-1:0] in_exp,
   input  wire logic [32-DT_FRACTION_BITS:0] in_lin_term,
   input  wire stdp_wu_pkg::cfg_type         cfg,
   output logic                              out_valid,
   output logic [15:0]                       out_weight_out,
   output logic                              out_potentiated,
   output logic                              out_capped
);
   import stdp_wu_pkg::*;

   localparam int P_W   = 32 - DT_FRACTION_BITS;
   localparam int G_W   = P_W + 1;
   localparam int FA_W  = P_W + 2;
   localparam int SUM_W = FA_W + 1;

   // Stage 4: step factor from linear segment or decay table
   item_ctl_type    s4_ctl_ff;
   logic            s4_neg_ff, s4_neg_in;
   logic [FA_W-1:0] s4_factor_ff, s4_factor_in;
   logic [15:0]     s4_w_ff;
   logic [G_W-1:0]  offset_g;

   assign offset_g = G_W'(cfg.window_offset);

   always_comb begin
      s4_neg_in = 1'b0;
      if (!in_ctl.linear) begin
         s4_factor_in = FA_W'(in_exp);
      end else if (in_ctl.potentiated) begin
         // Linear potentiation is g - F and may go negative
         if (in_lin_term >= offset_g) begin
            s4_factor_in = FA_W'(in_lin_term - offset_g);
         end else begin
            s4_factor_in = FA_W'(offset_g - in_lin_term);
            s4_neg_in    = 1'b1;
         end
      end else begin
         s4_factor_in = FA_W'(in_lin_term) + FA_W'(cfg.window_offset);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else if (advance) begin
         s4_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_neg_ff    <= s4_neg_in;
         s4_factor_ff <= s4_factor_in;
         s4_w_ff      <= in_weight;
      end
   end

   // Stage 5: scale by amplitude or depression rate
   logic [15:0]      amp;
   logic [15+FA_W:0] mag_prod;
   item_ctl_type     s5_ctl_ff;
   logic             s5_neg_ff;
   logic [FA_W-1:0]  s5_mag_ff;
   logic [15:0]      s5_w_ff;

   assign amp      = s4_ctl_ff.potentiated ? cfg.ltp_step : cfg.ltd_rate;
   assign mag_prod = (16 + FA_W)'(amp) * (16 + FA_W)'(s4_factor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ctl_ff <= '0;
      end else if (advance) begin
         s5_ctl_ff <= s4_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_neg_ff <= s4_neg_ff;
         s5_mag_ff <= mag_prod[15+FA_W:16];
         s5_w_ff   <= s4_w_ff;
      end
   end

   // Stage 6: add or subtract the step, or form the proportional decrement
   logic [15+FA_W:0] dec_prod;
   item_ctl_type     s6_ctl_ff;
   logic [SUM_W-1:0] s6_val_ff, s6_val_in;
   logic             s6_floor_ff, s6_floor_in;
   logic [15:0]      s6_w_ff;

   assign dec_prod = (16 + FA_W)'(s5_w_ff) * (16 + FA_W)'(s5_mag_ff);

   always_comb begin
      s6_floor_in = 1'b0;
      if (!s5_ctl_ff.potentiated) begin
         s6_val_in = SUM_W'(dec_prod[15+FA_W:16]);
      end else if (!s5_neg_ff) begin
         s6_val_in = SUM_W'(s5_w_ff) + SUM_W'(s5_mag_ff);
      end else if (s5_mag_ff > FA_W'(s5_w_ff)) begin
         s6_val_in   = '0;
         s6_floor_in = 1'b1;
      end else begin
         s6_val_in = SUM_W'(s5_w_ff) - SUM_W'(s5_mag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctl_ff <= '0;
      end else if (advance) begin
         s6_ctl_ff <= s5_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_val_ff   <= s6_val_in;
         s6_floor_ff <= s6_floor_in;
         s6_w_ff     <= s5_w_ff;
      end
   end

   // Stage 7: cap or floor into the output register
   logic        out_valid_ff;
   logic [15:0] out_weight_ff, out_weight_in;
   logic        out_pot_ff;
   logic        out_capped_ff, out_capped_in;

   always_comb begin
      if (s6_ctl_ff.potentiated) begin
         if (s6_val_ff > SUM_W'(cfg.weight_cap)) begin
            out_weight_in = cfg.weight_cap;
            out_capped_in = 1'b1;
         end else begin
            out_weight_in = s6_val_ff[15:0];
            out_capped_in = s6_floor_ff;
         end
      end else if (s6_val_ff > SUM_W'(s6_w_ff)) begin
         out_weight_in = '0;
         out_capped_in = 1'b1;
      end else begin
         out_weight_in = s6_w_ff - s6_val_ff[15:0];
         out_capped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s6_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_weight_ff <= out_weight_in;
         out_pot_ff    <= s6_ctl_ff.potentiated;
         out_capped_ff <= out_capped_in;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_weight_out  = out_weight_ff;
   assign out_potentiated = out_pot_ff;
   assign out_capped      = out_capped_ff;

   // Decay table entries never exceed one
   `STDP_ASSERT_HOLDS(a_exp_factor_le_one, s4_ctl_ff.valid && !s4_ctl_ff.linear, s4_factor_ff <= FA_W'(ONE_Q16), "decay factor above one")
   // Depression never raises the weight
   `STDP_ASSERT_NEXT(a_depress_no_growth, advance && s6_ctl_ff.valid && !s6_ctl_ff.potentiated, out_weight_ff <= $past(s6_w_ff), "depression increased weight")
   // A clamped potentiation lands on zero or on the cap
   `STDP_ASSERT_HOLDS(a_pot_clamp_value, out_valid_ff && out_pot_ff && out_capped_ff && (out_weight_ff != '0), out_weight_ff == cfg.weight_cap, "clamped weight off cap")

endmodule

`default_nettype wire

[design/stdp_weight_update.sv]
// Each req_ transfer reaches rsp_valid through the stage registers; one item per cycle while not stalled.
// The seven register stages advance together; a stall on the rsp_ side holds
// the output register and every stage behind it, so req_ready drops only while rsp_valid waits on rsp_ready.
// The decay table is a constant ROM read through a registered stage shared with the window offset product.
// Reset (synchronous) empties the pipeline and restores all configuration
// registers to their defaults; there is no clearing pass.
`default_nettype none
`include "stdp_weight_update_macros.svh"

module stdp_weight_update #(
   parameter int EXP_TABLE_DEPTH  = 256,
   parameter int DT_FRACTION_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [15:0]                         req_weight_in,
   input  wire logic [31:0]                         req_pre_spike_time,
   input  wire logic [31:0]                         req_post_spike_time,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [15:0]                              rsp_weight_out,
   output logic                                     rsp_potentiated,
   output logic                                     rsp_capped,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [stdp_wu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [15:0]                         csr_data
);
   import stdp_wu_pkg::*;

   cfg_type                        cfg;
   logic                           advance;
   item_ctl_type                   mid_ctl;
   logic [15:0]                    mid_weight;
   logic [EXP_ROM_W-1:0]           mid_exp;
   logic [32-DT_FRACTION_BITS:0]   mid_lin_term;

   // Whole pipeline moves when the output register is free or being drained
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   stdp_wu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   stdp_wu_timing #(
      .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH),
      .DT_FRACTION_BITS (DT_FRACTION_BITS)
   ) u_timing (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_valid),
      .in_weight    (req_weight_in),
      .in_pre_time  (req_pre_spike_time),
      .in_post_time (req_post_spike_time),
      .cfg          (cfg),
      .out_ctl      (mid_ctl),
      .out_weight   (mid_weight),
      .out_exp      (mid_exp),
      .out_lin_term (mid_lin_term)
   );

   stdp_wu_scale #(
      .DT_FRACTION_BITS (DT_FRACTION_BITS)
   ) u_scale (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_ctl          (mid_ctl),
      .in_weight       (mid_weight),
      .in_exp          (mid_exp),
      .in_lin_term     (mid_lin_term),
      .cfg             (cfg),
      .out_valid       (rsp_valid),
      .out_weight_out  (rsp_weight_out),
      .out_potentiated (rsp_potentiated),
      .out_capped      (rsp_capped)
   );

   // Potentiated results never exceed the configured cap
   `STDP_ASSERT_HOLDS(a_pot_within_cap, rsp_valid && rsp_potentiated, rsp_weight_out <= cfg.weight_cap, "potentiated weight above cap")
   // A clamped depression always floors at zero
   `STDP_ASSERT_HOLDS(a_dep_clamp_zero, rsp_valid && !rsp_potentiated && rsp_capped, rsp_weight_out == '0, "clamped depression not zero")
   // Configuration comes out of reset at its defaults
   `STDP_ASSERT_HOLDS(a_cfg_reset, $past(reset), cfg == CFG_RESET, "configuration not at reset values")

endmodule

`default_nettype wire

[dv/stdp_update_checker.sv]
// Scoreboard for the STDP weight update block: predicts each update and checks the rsp_ stream.
`timescale 1ns / 1ps

module stdp_update_checker #(
   parameter int EXP_TABLE_DEPTH  = 256,
   parameter int DT_FRACTION_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [15:0]                         req_weight_in,
   input  logic [31:0]                         req_pre_spike_time,
   input  logic [31:0]                         req_post_spike_time,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [15:0]                         rsp_weight_out,
   input  logic                                rsp_potentiated,
   input  logic                                rsp_capped,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [stdp_wu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                         csr_data,
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  checked,
   output int                                  potentiated_seen,
   output int                                  clamped_seen
);
   import stdp_wu_pkg::*;

   localparam int MAX_REPORTS = 40;

   typedef struct {
      logic [15:0] w_in;
      logic [31:0] pre;
      logic [31:0] post;
      logic [15:0] weight;
      logic        potentiated;
      logic        capped;
   } update_rec_type;

   cfg_type        shadow_cfg = CFG_RESET;
   update_rec_type pending_updates[$];
   logic [16:0]    decay_rom [EXP_TABLE_DEPTH];

   // exp(-x/20ms) table, one entry per whole ms, accumulated in Q1.32 and rounded
   initial begin : build_decay_rom
      logic [95:0] acc;
      acc = 96'd1 << 32;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         decay_rom[k] = 17'((acc + (96'd1 << 15)) >> 16);
         acc = (acc * EXP_STEP_Q32 + (96'd1 << 31)) >> 32;
      end
   end

   function automatic logic [63:0] decay_at(input logic [63:0] excess);
      logic [63:0] idx;
      idx = excess >> DT_FRACTION_BITS;
      if (idx > EXP_TABLE_DEPTH - 1) idx = EXP_TABLE_DEPTH - 1;
      return 64'(decay_rom[idx]);
   endfunction

   // Expected update for one synapse under the given settings
   function automatic update_rec_type predict_update(input cfg_type c,
                                                     input logic [15:0] w_in,
                                                     input logic [31:0] pre,
                                                     input logic [31:0] post);
      update_rec_type r;
      logic [63:0] w, dt, p, g, s, mag, d, f, dec, res;
      logic        neg;
      r.w_in    = w_in;
      r.pre     = pre;
      r.post    = post;
      r.capped  = 1'b0;
      w         = 64'(w_in);
      neg       = 1'b0;
      if (pre <= post) begin
         r.potentiated = 1'b1;
         dt = 64'(post - pre);
         if (dt <= 64'(c.ltp_window)) begin
            // linear segment, step may go negative near dt = 0
            p = (dt * c.ltp_window_recip) >> DT_FRACTION_BITS;
            g = ((64'd65536 + c.window_offset) * p) >> 16;
            if (g >= c.window_offset) begin
               s = g - c.window_offset;
            end else begin
               s   = c.window_offset - g;
               neg = 1'b1;
            end
            mag = (c.ltp_step * s) >> 16;
         end else begin
            mag = (c.ltp_step * decay_at(dt - c.ltp_window)) >> 16;
         end
         if (neg) begin
            if (mag > w) begin
               res      = 0;
               r.capped = 1'b1;
            end else begin
               res = w - mag;
            end
         end else begin
            res = w + mag;
         end
         if (res > c.weight_cap) begin
            res      = c.weight_cap;
            r.capped = 1'b1;
         end
      end else begin
         r.potentiated = 1'b0;
         dt = 64'(pre - post);
         if (dt <= 64'(c.ltd_window)) begin
            p = (dt * c.ltd_window_recip) >> DT_FRACTION_BITS;
            f = (((64'd65536 - c.window_offset) * p) >> 16) + c.window_offset;
            d = (c.ltd_rate * f) >> 16;
         end else begin
            d = (c.ltd_rate * decay_at(dt - c.ltd_window)) >> 16;
         end
         // depression has only a floor, never the cap
         dec = (w * d) >> 16;
         if (dec > w) begin
            res      = 0;
            r.capped = 1'b1;
         end else begin
            res = w - dec;
         end
      end
      r.weight = res[15:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // Watch all three channels; registers change only between bursts of traffic
   always @(posedge clock) begin : scoreboard
      update_rec_type want;
      if (reset) begin
         shadow_cfg = CFG_RESET;
         pending_updates.delete();
      end else begin
         if (req_valid && req_ready)
            pending_updates.insert(pending_updates.size(),
                                   predict_update(shadow_cfg, req_weight_in,
                                                  req_pre_spike_time,
                                                  req_post_spike_time));
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LTP_STEP:      shadow_cfg.ltp_step         = csr_data;
               CSR_LTD_RATE:      shadow_cfg.ltd_rate         = csr_data;
               CSR_WINDOW_OFFSET: shadow_cfg.window_offset    = csr_data;
               CSR_WEIGHT_CAP:    shadow_cfg.weight_cap       = csr_data;
               CSR_LTP_WINDOW:    shadow_cfg.ltp_window       = csr_data;
               CSR_LTD_WINDOW:    shadow_cfg.ltd_window       = csr_data;
               CSR_LTP_RECIP:     shadow_cfg.ltp_window_recip = csr_data;
               CSR_LTD_RECIP:     shadow_cfg.ltd_window_recip = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_updates.size() == 0) begin
               report_mismatch($sformatf("result transfer with nothing expected, weight_out %0d",
                                         rsp_weight_out));
            end else begin
               want = pending_updates.pop_front();
               checked++;
               if (want.potentiated) potentiated_seen++;
               if (want.capped) clamped_seen++;
               if (rsp_weight_out !== want.weight)
                  report_mismatch($sformatf("weight_out %0d, want %0d (w %0d pre %h post %h)",
                                            rsp_weight_out, want.weight, want.w_in,
                                            want.pre, want.post));
               if (rsp_potentiated !== want.potentiated)
                  report_mismatch($sformatf("potentiated %b, want %b (pre %h post %h)",
                                            rsp_potentiated, want.potentiated,
                                            want.pre, want.post));
               if (rsp_capped !== want.capped)
                  report_mismatch($sformatf("capped %b, want %b (w %0d pre %h post %h)",
                                            rsp_capped, want.capped, want.w_in,
                                            want.pre, want.post));
            end
         end
      end
      outstanding = pending_updates.size();
   end

endmodule

[dv/stdp_weight_update_tb.sv]
// Testbench top for stdp_weight_update: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module stdp_weight_update_tb;
   import stdp_wu_pkg::*;

   localparam int EXP_TABLE_DEPTH  = 256;
   localparam int DT_FRACTION_BITS = 8;
   localparam int NUM_PHASES       = 8;
   localparam int ITEMS_PER_PHASE  = 125;
   localparam int DRAIN_CYCLES     = 20;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int HOLD_PHASE       = 3;

   logic                   clock               = 1'b0;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_ready;
   logic [15:0]            req_weight_in       = '0;
   logic [31:0]            req_pre_spike_time  = '0;
   logic [31:0]            req_post_spike_time = '0;
   logic                   rsp_valid;
   logic                   rsp_ready           = 1'b0;
   logic [15:0]            rsp_weight_out;
   logic                   rsp_potentiated;
   logic                   rsp_capped;
   logic                   csr_valid           = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index           = '0;
   logic [15:0]            csr_data            = '0;

   int mismatches, outstanding, checked, potentiated_seen, clamped_seen;

   cfg_type active_cfg    = CFG_RESET;
   bit      tx_gaps       = 1'b1;
   bit      rx_gaps       = 1'b1;
   logic    long_hold_req = 1'b0;
   int      input_stall_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   stdp_weight_update #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
      .DT_FRACTION_BITS(DT_FRACTION_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_weight_in      (req_weight_in),
      .req_pre_spike_time (req_pre_spike_time),
      .req_post_spike_time(req_post_spike_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_weight_out     (rsp_weight_out),
      .rsp_potentiated    (rsp_potentiated),
      .rsp_capped         (rsp_capped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   stdp_update_checker #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
      .DT_FRACTION_BITS(DT_FRACTION_BITS)
   ) update_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_weight_in      (req_weight_in),
      .req_pre_spike_time (req_pre_spike_time),
      .req_post_spike_time(req_post_spike_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_weight_out     (rsp_weight_out),
      .rsp_potentiated    (rsp_potentiated),
      .rsp_capped         (rsp_capped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .checked            (checked),
      .potentiated_seen   (potentiated_seen),
      .clamped_seen       (clamped_seen)
   );

   // Hard stop in case a handshake never completes
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Back-pressure bookkeeping for the summary
   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) input_stall_cycles++;
   end

   // Result side: random gaps, plus one long hold on request
   initial begin : result_sink
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req <= 1'b0;
         end else begin
            gap = rx_gaps ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && !long_hold_req);
      end
   end

   // Offer one synapse update; valid stays high afterwards unless the next one idles first
   task automatic send_update(input logic [15:0] w, input logic [31:0] pre,
                              input logic [31:0] post);
      int gap;
      gap = tx_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_weight_in       <= w;
      req_pre_spike_time  <= pre;
      req_post_spike_time <= post;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every update has come back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_settings(input cfg_type c);
      write_reg(CSR_LTP_STEP,      c.ltp_step);
      write_reg(CSR_LTD_RATE,      c.ltd_rate);
      write_reg(CSR_WINDOW_OFFSET, c.window_offset);
      write_reg(CSR_WEIGHT_CAP,    c.weight_cap);
      write_reg(CSR_LTP_WINDOW,    c.ltp_window);
      write_reg(CSR_LTD_WINDOW,    c.ltd_window);
      write_reg(CSR_LTP_RECIP,     c.ltp_window_recip);
      write_reg(CSR_LTD_RECIP,     c.ltd_window_recip);
      csr_valid <= 1'b0;
   endtask

   // Register sets: defaults, both extremes, sane random windows, then anything goes
   function automatic cfg_type settings_for_phase(input int phase);
      cfg_type c;
      int unsigned win;
      case (phase)
         0: c = CFG_RESET;
         1: c = '0;
         2: c = '1;
         NUM_PHASES - 1: begin
            c.ltp_step         = 16'($urandom);
            c.ltd_rate         = 16'($urandom);
            c.window_offset    = 16'($urandom);
            c.weight_cap       = 16'($urandom);
            c.ltp_window       = 16'($urandom);
            c.ltd_window       = 16'($urandom);
            c.ltp_window_recip = 16'($urandom);
            c.ltd_window_recip = 16'($urandom);
         end
         default: begin
            c.ltp_step      = 16'($urandom);
            c.ltd_rate      = 16'($urandom);
            c.window_offset = 16'($urandom);
            c.weight_cap    = 16'($urandom);
            win                = $urandom_range(1, 8191);
            c.ltp_window       = 16'(win);
            c.ltp_window_recip = 16'(((1 << 24) / win > 65535) ? 65535 : (1 << 24) / win);
            win                = $urandom_range(1, 8191);
            c.ltd_window       = 16'(win);
            c.ltd_window_recip = 16'(((1 << 24) / win > 65535) ? 65535 : (1 << 24) / win);
         end
      endcase
      return c;
   endfunction

   // Spike distance: inside the window, on its edge, in the decay tail, anywhere, or tiny
   function automatic logic [31:0] pick_dt(input logic [15:0] window);
      int unsigned win;
      win = window;
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, win);
         1:       return $urandom_range((win > 2) ? win - 2 : 0, win + 2);
         2:       return win + $urandom_range(1, 70000);
         3:       return $urandom;
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   task automatic random_update();
      logic [15:0] w;
      logic [31:0] dt, base;
      bit          ltp;
      ltp = $urandom_range(0, 1);
      dt  = pick_dt(ltp ? active_cfg.ltp_window : active_cfg.ltd_window);
      // equal times always count as potentiation
      if (!ltp && dt == 0) dt = 1;
      base = $urandom_range(0, 32'hFFFF_FFFF - dt);
      case ($urandom_range(0, 5))
         0:       w = 16'h0000;
         1:       w = 16'hFFFF;
         2:       w = active_cfg.weight_cap - 16'd2 + 16'($urandom_range(0, 4));
         default: w = 16'($urandom);
      endcase
      if (ltp) send_update(w, base, base + dt);
      else     send_update(w, base + dt, base);
   endtask

   initial begin : stimulus
      logic [31:0] tp, td;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      tp = active_cfg.ltp_window;
      td = active_cfg.ltd_window;

      // Directed corners under the reset settings
      send_update(16'd0,     32'd0,          32'd0);           // equal times, negative step
      send_update(16'hFFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);   // already above cap
      send_update(16'd1000,  32'd100,        32'd100 + tp);    // potentiation window edge
      send_update(16'd1000,  32'd100,        32'd101 + tp);    // first decay entry
      send_update(16'd18022, 32'd5000,       32'd5640);        // mid window, at cap
      send_update(16'd18021, 32'd7,          32'd8);           // near cap, tiny dt
      send_update(16'd17000, 32'd0,          32'hFFFF_FFFF);   // far tail, saturated index
      send_update(16'd500,   32'd0,          tp + 255 * 256);  // last table entry exactly
      send_update(16'd500,   32'd0,          tp + 256 * 256);  // one past the table
      send_update(16'd30000, td,             32'd0);           // depression window edge
      send_update(16'd30000, td + 1,         32'd0);           // depression decay
      send_update(16'hFFFF,  32'hFFFF_FFFF,  32'd0);           // depression above cap
      send_update(16'd0,     32'd1,          32'd0);           // depression of zero
      send_update(16'hFFFF,  32'd1,          32'd0);           // full weight, tiny dt
      send_update(16'd40000, td + 300 * 256, 32'd0);           // depression saturated tail
      send_update(16'hAAAA,  32'h5555_5555,  32'hAAAA_AAAA);
      send_update(16'h5555,  32'hAAAA_AAAA,  32'h5555_5555);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            drain_pipeline();
            active_cfg = settings_for_phase(phase);
            program_settings(active_cfg);
         end
         tx_gaps = !(phase == 1 || phase == HOLD_PHASE);
         rx_gaps = !(phase == 2 || phase == 5);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // sender keeps streaming while the result side holds off
            if (phase == HOLD_PHASE && i == 40) long_hold_req <= 1'b1;
            random_update();
         end
      end
      drain_pipeline();

      $display("Run covered %0d register sets; %0d updates checked, %0d potentiation, %0d clamped.",
               NUM_PHASES, checked, potentiated_seen, clamped_seen);
      $display("Input was held off for %0d cycles by result-side back-pressure.",
               input_stall_cycles);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
